### hw/rtl/sparse_sketch_accumulate_top_assert.svh
// Assertion macros used by the checker of the sparse sketch accumulator.
// Each macro expands to one labeled concurrent assertion on clk_i, disabled in reset.
`ifndef SPARSE_SKETCH_ACCUMULATE_TOP_ASSERT_SVH
`define SPARSE_SKETCH_ACCUMULATE_TOP_ASSERT_SVH

// Same-cycle implication; the consequent may carry its own constant delay.
`define SSA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("sparse sketch accumulator check failed");

// Next-cycle implication.
`define SSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sparse sketch accumulator check failed");

`endif

### hw/rtl/ssa_pkg.sv
// Package of the sparse sketch accumulator: field widths, operation codes,
// controller states and the command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssa_pkg;

  localparam int OP_W      = 2;
  localparam int ROWID_W   = 8;
  localparam int LANE_W    = 16;
  localparam int PROD_W    = 32;
  localparam int SUM_W     = 40;
  localparam int MAX_LANES = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic capture;
    logic clr_en;
    logic mem_rd;
    logic mul_en;
    logic exec_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/sparse_sketch_accumulate_top.sv
// Top level of the sparse sketch accumulator: joins the controller and the datapath.
// Depends on ssa_pkg, ssa_ctrl and ssa_dp.
//
// Usage: one input channel (valid_i/stall_o) carries items: accumulate adds
// weight times each lane value into a sketch row with 40-bit saturation, read
// returns the row's sums, clear zeroes the row. Opcode 3 and out-of-range rows
// change nothing; a read of an out-of-range row returns zero sums.
// One output channel (valid_o/stall_i) carries read results only.
// Each item passes through the transfer, then the memory read, multiply and
// execute steps; the row memory has a single port and the next item enters only
// after the execute step, so the block takes no new item until the last is through.
// A read result is loaded in the execute step and waits in the output
// register while stall_i is high, and a second read then holds in the execute
// step until that register is taken. Other items continue meanwhile.
// After reset the block sweeps the memory to zero, one row per cycle, over all
// SKETCH_ROWS rows with stall_o high before the first transfer.
`timescale 1ns / 1ps
`default_nettype none

module sparse_sketch_accumulate_top #(
  parameter int SKETCH_ROWS = 256,
  parameter int LANES       = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic [ssa_pkg::OP_W-1:0]            opcode_i,
  input  logic [ssa_pkg::ROWID_W-1:0]         target_row_i,
  input  logic signed [ssa_pkg::LANE_W-1:0]   weight_i,
  input  logic signed [ssa_pkg::LANE_W-1:0]   lane0_value_i,
  input  logic signed [ssa_pkg::LANE_W-1:0]   lane1_value_i,
  input  logic signed [ssa_pkg::LANE_W-1:0]   lane2_value_i,
  input  logic signed [ssa_pkg::LANE_W-1:0]   lane3_value_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic [ssa_pkg::ROWID_W-1:0]         read_row_o,
  output logic signed [ssa_pkg::SUM_W-1:0]    lane0_sum_o,
  output logic signed [ssa_pkg::SUM_W-1:0]    lane1_sum_o,
  output logic signed [ssa_pkg::SUM_W-1:0]    lane2_sum_o,
  output logic signed [ssa_pkg::SUM_W-1:0]    lane3_sum_o
);
  import ssa_pkg::*;

  dp_cmd_t                              cmd;
  dp_sts_t                              sts;
  logic [MAX_LANES-1:0][LANE_W-1:0]     lanes;
  logic [MAX_LANES-1:0][SUM_W-1:0]      sums;

  assign lanes = {lane3_value_i, lane2_value_i, lane1_value_i, lane0_value_i};

  ssa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  ssa_dp #(
    .SKETCH_ROWS (SKETCH_ROWS),
    .LANES       (LANES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (opcode_i),
    .target_row_i (target_row_i),
    .weight_i     (weight_i),
    .lane_i       (lanes),
    .stall_i      (stall_i),
    .valid_o      (valid_o),
    .read_row_o   (read_row_o),
    .sum_o        (sums)
  );

  assign lane0_sum_o = sums[0];
  assign lane1_sum_o = sums[1];
  assign lane2_sum_o = sums[2];
  assign lane3_sum_o = sums[3];

endmodule

`default_nettype wire

### hw/rtl/ssa_ctrl.sv
// Controller of the sparse sketch accumulator: the state machine that sequences
// the clearing pass and each item. Depends on ssa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  ssa_pkg::dp_sts_t sts_i,
  output ssa_pkg::dp_cmd_t cmd_o
);
  import ssa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (valid_i) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts_i.is_read || sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    stall_o = 1'b1;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clr_en = 1'b1;
      end
      ST_IDLE: begin
        stall_o       = 1'b0;
        cmd_o.capture = valid_i;
      end
      ST_FETCH: begin
        cmd_o.mem_rd = 1'b1;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
      end
      ST_EXEC: begin
        if (sts_i.is_read) begin
          cmd_o.out_load = sts_i.out_free;
        end else begin
          cmd_o.exec_wr = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/ssa_dp.sv
// Datapath of the sparse sketch accumulator: item registers, the row memory,
// lane multipliers, saturating adders and the output register. Depends on ssa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssa_dp #(
  parameter int SKETCH_ROWS = 256,
  parameter int LANES       = 4
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  ssa_pkg::dp_cmd_t                                      cmd_i,
  output ssa_pkg::dp_sts_t                                      sts_o,
  input  logic [ssa_pkg::OP_W-1:0]                              opcode_i,
  input  logic [ssa_pkg::ROWID_W-1:0]                           target_row_i,
  input  logic [ssa_pkg::LANE_W-1:0]                            weight_i,
  input  logic [ssa_pkg::MAX_LANES-1:0][ssa_pkg::LANE_W-1:0]   lane_i,
  input  logic                                                  stall_i,
  output logic                                                  valid_o,
  output logic [ssa_pkg::ROWID_W-1:0]                           read_row_o,
  output logic [ssa_pkg::MAX_LANES-1:0][ssa_pkg::SUM_W-1:0]    sum_o
);
  import ssa_pkg::*;

  localparam int ROW_W = $clog2(SKETCH_ROWS);
  localparam int MEM_W = LANES * SUM_W;
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  op_e                 op_q;
  logic [ROWID_W-1:0]  row_q;
  logic [LANE_W-1:0]   weight_q;
  logic [ROW_W-1:0]    clr_cnt_q;
  logic [MEM_W-1:0]    mem_q [SKETCH_ROWS];
  logic [MEM_W-1:0]    rd_data_q;
  logic [MEM_W-1:0]    wr_data;
  logic                out_valid_q;
  logic [ROWID_W-1:0]  out_row_q;
  logic [ROW_W+ROWID_W-1:0] row_ext;
  logic [ROW_W-1:0]    addr;
  logic                row_ok;
  logic                out_free;

  assign row_ext  = {{ROW_W{1'b0}}, row_q};
  assign addr     = row_ext[ROW_W-1:0];
  assign row_ok   = {{(32-ROWID_W){1'b0}}, row_q} < 32'(SKETCH_ROWS);
  assign out_free = !out_valid_q || !stall_i;

  assign sts_o.clr_last = (clr_cnt_q == ROW_W'(SKETCH_ROWS - 1));
  assign sts_o.is_read  = (op_q == OP_READ);
  assign sts_o.out_free = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= op_e'(opcode_i);
      row_q    <= target_row_i;
      weight_q <= weight_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (cmd_i.exec_wr && row_ok && (op_q == OP_ACC || op_q == OP_CLEAR)) begin
      mem_q[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rd_data_q <= mem_q[addr];
    end
  end

  for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
    if (k < LANES) begin : g_used
      logic [LANE_W-1:0]        lane_q;
      logic signed [PROD_W-1:0] prod_q;
      logic [SUM_W-1:0]         acc;
      logic [SUM_W:0]           sum_ext;
      logic [SUM_W-1:0]         sat;
      logic [SUM_W-1:0]         out_sum_q;

      always_ff @(posedge clk_i) begin
        if (cmd_i.capture) begin
          lane_q <= lane_i[k];
        end
      end

      always_ff @(posedge clk_i) begin
        if (cmd_i.mul_en) begin
          prod_q <= $signed(weight_q) * $signed(lane_q);
        end
      end

      assign acc     = rd_data_q[k*SUM_W +: SUM_W];
      assign sum_ext = {acc[SUM_W-1], acc}
                     + {{(SUM_W+1-PROD_W){prod_q[PROD_W-1]}}, prod_q};

      always_comb begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
          sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
          sat = sum_ext[SUM_W-1:0];
        end
      end

      assign wr_data[k*SUM_W +: SUM_W] = (op_q == OP_CLEAR) ? '0 : sat;

      always_ff @(posedge clk_i) begin
        if (cmd_i.out_load) begin
          out_sum_q <= row_ok ? acc : '0;
        end
      end

      assign sum_o[k] = out_sum_q;
    end else begin : g_unused
      assign sum_o[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_row_q <= row_q;
    end
  end

  assign valid_o    = out_valid_q;
  assign read_row_o = out_row_q;

endmodule

`default_nettype wire

### hw/rtl/ssa_checker.sv
// Port-level checker of the sparse sketch accumulator and its bind to the top level.
// Depends on ssa_pkg and sparse_sketch_accumulate_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sparse_sketch_accumulate_top_assert.svh"

module ssa_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             valid_i,
  input logic                             stall_o,
  input logic                             valid_o,
  input logic                             stall_i,
  input logic [ssa_pkg::ROWID_W-1:0]      read_row_o,
  input logic [ssa_pkg::SUM_W-1:0]        lane0_sum_o,
  input logic [ssa_pkg::SUM_W-1:0]        lane1_sum_o,
  input logic [ssa_pkg::SUM_W-1:0]        lane2_sum_o,
  input logic [ssa_pkg::SUM_W-1:0]        lane3_sum_o
);
  import ssa_pkg::*;

  logic                                 in_xfer;
  logic                                 out_held;
  logic [ROWID_W+MAX_LANES*SUM_W-1:0]   out_payload;

  assign in_xfer     = valid_i && !stall_o;
  assign out_held    = valid_o && stall_i;
  assign out_payload = {read_row_o, lane0_sum_o, lane1_sum_o, lane2_sum_o, lane3_sum_o};

  // The block works on one item at a time through its fetch and multiply steps.
  `SSA_ASSERT_NEXT(a_busy_after_xfer, in_xfer, stall_o)
  `SSA_ASSERT_IMPLY(a_busy_two_after_xfer, in_xfer, ##2 stall_o)
  `SSA_ASSERT_NEXT(a_out_valid_holds, out_held, valid_o)
  `SSA_ASSERT_NEXT(a_out_payload_holds, out_held, $stable(out_payload))

endmodule

bind sparse_sketch_accumulate_top ssa_checker u_ssa_checker (.*);

`default_nettype wire

### sim/tb_sparse_sketch_accumulate_top.sv
// Self-checking testbench for sparse_sketch_accumulate_top: a directed table, mixed random
// traffic and a long saturation run, with random gaps on both handshakes.
// Depends on ssa_pkg and the RTL of the accumulator; every read result is checked in order.
`timescale 1ns / 1ps

module tb_sparse_sketch_accumulate_top;
  import ssa_pkg::*;

  localparam int ROWS        = 256;
  localparam int LANE_COUNT  = 4;
  localparam int DIR_N       = 23;
  localparam int MIXED_ITEMS = 40;
  localparam int SAT_ITEMS   = 560;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint SUM_MAX = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -(64'sd1 <<< (SUM_W - 1));

  typedef struct packed {
    op_e                             op;
    logic [ROWID_W-1:0]              row;
    logic [LANE_W-1:0]               weight;
    logic [0:MAX_LANES-1][LANE_W-1:0] lane;
    logic                            typed;
    logic [0:MAX_LANES-1][SUM_W-1:0] sum;
  } sketch_step_t;

  typedef struct packed {
    logic [ROWID_W-1:0]              row;
    logic [0:MAX_LANES-1][SUM_W-1:0] sum;
  } row_readout_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      valid_i       = 1'b0;
  logic                      stall_o;
  logic [OP_W-1:0]           opcode_i      = '0;
  logic [ROWID_W-1:0]        target_row_i  = '0;
  logic signed [LANE_W-1:0]  weight_i      = '0;
  logic signed [LANE_W-1:0]  lane0_value_i = '0;
  logic signed [LANE_W-1:0]  lane1_value_i = '0;
  logic signed [LANE_W-1:0]  lane2_value_i = '0;
  logic signed [LANE_W-1:0]  lane3_value_i = '0;
  logic                      valid_o;
  logic                      stall_i       = 1'b0;
  logic [ROWID_W-1:0]        read_row_o;
  logic signed [SUM_W-1:0]   lane0_sum_o;
  logic signed [SUM_W-1:0]   lane1_sum_o;
  logic signed [SUM_W-1:0]   lane2_sum_o;
  logic signed [SUM_W-1:0]   lane3_sum_o;

  longint       row_sums [ROWS][MAX_LANES];
  row_readout_t pending_reads [$];
  int           op_count [4];
  int           mismatch_count = 0;
  int           reads_checked  = 0;
  int           clamp_count    = 0;
  int           cycle_count    = 0;
  bit           src_steady     = 1'b0;
  bit           sink_steady    = 1'b0;

  sketch_step_t directed_steps [DIR_N] = '{
    '{OP_READ,  8'd0,   16'h0000, {4{16'h0000}}, 1'b1, '0},
    '{OP_READ,  8'd255, 16'h0000, {4{16'h0000}}, 1'b1, '0},
    '{OP_ACC,   8'd3,   16'h8000, {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF}, 1'b0, '0},
    '{OP_READ,  8'd3,   16'h0000, {4{16'h0000}}, 1'b1,
      {40'h00_4000_0000, 40'hFF_C000_8000, 40'h00_0000_0000, 40'h00_0000_8000}},
    '{OP_ACC,   8'd3,   16'h7FFF, {16'h7FFF, 16'h8000, 16'h0001, 16'h8000}, 1'b0, '0},
    '{OP_READ,  8'd3,   16'h0000, {4{16'h0000}}, 1'b0, '0},
    '{OP_CLEAR, 8'd3,   16'h7FFF, {4{16'h7FFF}}, 1'b0, '0},
    '{OP_READ,  8'd3,   16'h0000, {4{16'h0000}}, 1'b1, '0},
    '{OP_NONE,  8'd5,   16'h7FFF, {4{16'h7FFF}}, 1'b0, '0},
    '{OP_READ,  8'd5,   16'h0000, {4{16'h0000}}, 1'b1, '0},
    '{OP_ACC,   8'd255, 16'h0000, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 1'b0, '0},
    '{OP_READ,  8'd255, 16'h0000, {4{16'h0000}}, 1'b1, '0},
    '{OP_ACC,   8'd255, 16'h0001, {16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000}, 1'b0, '0},
    '{OP_READ,  8'd255, 16'h0000, {4{16'h0000}}, 1'b1,
      {40'h00_0000_0001, 40'hFF_FFFF_FFFF, 40'h00_0000_7FFF, 40'hFF_FFFF_8000}},
    '{OP_ACC,   8'd7,   16'hA5A5, {16'h1234, 16'hEDCB, 16'h5A5A, 16'h8001}, 1'b0, '0},
    '{OP_ACC,   8'd7,   16'h5A5A, {16'hFEDC, 16'h0123, 16'hA5A5, 16'h7FFE}, 1'b0, '0},
    '{OP_READ,  8'd7,   16'h0000, {4{16'h0000}}, 1'b0, '0},
    '{OP_READ,  8'd7,   16'h0000, {4{16'h0000}}, 1'b0, '0},
    '{OP_CLEAR, 8'd7,   16'h0000, {4{16'h0000}}, 1'b0, '0},
    '{OP_ACC,   8'd7,   16'hFFFF, {16'h8000, 16'h0001, 16'h7FFF, 16'hFFFF}, 1'b0, '0},
    '{OP_READ,  8'd7,   16'h0000, {4{16'h0000}}, 1'b0, '0},
    '{OP_CLEAR, 8'd200, 16'hFFFF, {4{16'hFFFF}}, 1'b0, '0},
    '{OP_READ,  8'd200, 16'h0000, {4{16'h0000}}, 1'b1, '0}
  };

  sparse_sketch_accumulate_top #(
    .SKETCH_ROWS(ROWS),
    .LANES      (LANE_COUNT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .opcode_i     (opcode_i),
    .target_row_i (target_row_i),
    .weight_i     (weight_i),
    .lane0_value_i(lane0_value_i),
    .lane1_value_i(lane1_value_i),
    .lane2_value_i(lane2_value_i),
    .lane3_value_i(lane3_value_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .read_row_o   (read_row_o),
    .lane0_sum_o  (lane0_sum_o),
    .lane1_sum_o  (lane1_sum_o),
    .lane2_sum_o  (lane2_sum_o),
    .lane3_sum_o  (lane3_sum_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d reads outstanding.",
               cycle_count, pending_reads.size());
      $display("[sparse_sketch_accumulate_top] ERROR");
      $finish;
    end
  end

  // Updates the sketch rows for one transferred item and queues the readout it produces.
  task automatic update_sketch(input sketch_step_t s);
    longint       total;
    row_readout_t r;
    int           k;
    bit           row_ok;
    row_ok = (int'(s.row) < ROWS);
    r.row  = s.row;
    r.sum  = '0;
    op_count[s.op]++;
    case (s.op)
      OP_ACC: begin
        if (row_ok) begin
          for (k = 0; k < LANE_COUNT; k++) begin
            total = row_sums[s.row][k] +
                    longint'($signed(s.weight)) * longint'($signed(s.lane[k]));
            if (total > SUM_MAX || total < SUM_MIN) clamp_count++;
            if (total > SUM_MAX) total = SUM_MAX;
            if (total < SUM_MIN) total = SUM_MIN;
            row_sums[s.row][k] = total;
          end
        end
      end
      OP_READ: begin
        for (k = 0; k < LANE_COUNT; k++) begin
          if (row_ok) r.sum[k] = SUM_W'(row_sums[s.row][k]);
        end
        if (s.typed) r.sum = s.sum;
        pending_reads.push_back(r);
      end
      OP_CLEAR: begin
        if (row_ok) begin
          for (k = 0; k < LANE_COUNT; k++) row_sums[s.row][k] = 0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_step(input sketch_step_t s);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    opcode_i      <= s.op;
    target_row_i  <= s.row;
    weight_i      <= s.weight;
    lane0_value_i <= s.lane[0];
    lane1_value_i <= s.lane[1];
    lane2_value_i <= s.lane[2];
    lane3_value_i <= s.lane[3];
    @(posedge clk_i);
    while (stall_o !== 1'b0) @(posedge clk_i);
    update_sketch(s);
  endtask

  task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatch_count++;
    end
  endtask

  initial begin : result_sink
    int unsigned  hold;
    row_readout_t want;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_steady = !sink_steady;
      hold = sink_steady ? 0 : $urandom_range(0, 4);
      if (hold != 0) begin
        stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      @(posedge clk_i);
      while (valid_o !== 1'b1) @(posedge clk_i);
      if (pending_reads.size() == 0) begin
        $error("read_row: expected no transfer, got row %0d", read_row_o);
        mismatch_count++;
      end else begin
        want = pending_reads.pop_front();
        check_field("read_row", SUM_W'(want.row), SUM_W'(read_row_o));
        check_field("lane0_sum", want.sum[0], lane0_sum_o);
        check_field("lane1_sum", want.sum[1], lane1_sum_o);
        check_field("lane2_sum", want.sum[2], lane2_sum_o);
        check_field("lane3_sum", want.sum[3], lane3_sum_o);
        reads_checked++;
      end
    end
  end

  initial begin : stimulus
    sketch_step_t       s;
    logic [ROWID_W-1:0] hot_rows [8];
    logic [ROWID_W-1:0] sat_row;
    int                 n;
    int                 k;
    int                 pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < DIR_N; n++) send_step(directed_steps[n]);

    // Mixed traffic concentrates on a few rows so that reads see deep sums.
    for (k = 0; k < 8; k++) hot_rows[k] = ROWID_W'($urandom);
    for (n = 0; n < MIXED_ITEMS; n++) begin
      s    = '0;
      pick = $urandom_range(0, 19);
      s.op = (pick < 11) ? OP_ACC : (pick < 16) ? OP_READ : (pick < 19) ? OP_CLEAR : OP_NONE;
      s.row = ($urandom_range(0, 3) != 0) ? hot_rows[$urandom_range(0, 7)]
                                          : ROWID_W'($urandom);
      s.weight = ($urandom_range(0, 4) == 0) ?
                 (($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF) : LANE_W'($urandom);
      for (k = 0; k < MAX_LANES; k++) begin
        s.lane[k] = ($urandom_range(0, 4) == 0) ?
                    (($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF) : LANE_W'($urandom);
      end
      send_step(s);
    end

    // Near-full-scale products drive lanes 0 and 2 to the upper bound and lane 1 to the
    // lower bound; the closing items reverse the sign to pull the sums off the bounds.
    sat_row = ROWID_W'($urandom);
    for (n = 0; n < SAT_ITEMS; n++) begin
      s     = '0;
      s.row = sat_row;
      if ((n % 40) == 39 || n == SAT_ITEMS - 1) begin
        s.op = OP_READ;
      end else begin
        s.op      = OP_ACC;
        s.weight  = (n < SAT_ITEMS - 12) ? 16'h8000 : 16'h7FFF;
        s.lane[0] = 16'h8000 | LANE_W'($urandom_range(0, 255));
        s.lane[1] = 16'h7F00 | LANE_W'($urandom_range(0, 255));
        s.lane[2] = 16'h8000 | LANE_W'($urandom_range(0, 255));
        s.lane[3] = LANE_W'($urandom);
      end
      send_step(s);
    end

    valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Transferred %0d accumulate, %0d read, %0d clear and %0d unused-opcode items.",
             op_count[OP_ACC], op_count[OP_READ], op_count[OP_CLEAR], op_count[OP_NONE]);
    $display("Checked %0d read results; %0d lane additions were clamped to a bound.",
             reads_checked, clamp_count);
    if (mismatch_count == 0) begin
      $display("[sparse_sketch_accumulate_top] OK");
    end else begin
      $display("[sparse_sketch_accumulate_top] ERROR");
    end
    $finish;
  end

endmodule
